@@ rtl/rtbe_pkg.sv @@
`timescale 1ns / 1ps

package rtbe_pkg;

  // Field and datapath widths
  localparam int unsigned BudgetW = 10;
  localparam int unsigned OscW    = 16;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned DataW   = 32;
  localparam int unsigned ExpW    = 5;
  localparam int unsigned CntW    = 6;

  // Parameter limits and conversion constants
  localparam logic [BudgetW-1:0] BUDGET_MIN_MS    = 10'd10;
  localparam logic [BudgetW-1:0] BUDGET_MAX_MS    = 10'd200;
  localparam logic [DataW-1:0]   MS_TO_US         = 32'd1000;
  localparam logic [DataW-1:0]   BUDGET_OFFSET_US = 32'd2500;
  localparam logic [11:0]        MACRO_MULT       = 12'd2304;
  localparam logic [DataW-1:0]   OSC_NUMERATOR    = 32'h4000_0000;
  localparam logic [DataW-1:0]   HIGH_MASK        = 32'hFFFF_FF00;
  localparam logic [DataW-1:0]   SCALE_A          = 32'd16;
  localparam logic [DataW-1:0]   SCALE_B          = 32'd12;

  // Divider operand select codes
  localparam logic [1:0] SEL_OSC = 2'd0;
  localparam logic [1:0] SEL_A   = 2'd1;
  localparam logic [1:0] SEL_B   = 2'd2;

  typedef struct packed {
    logic [BudgetW-1:0] budget_ms;
    logic [OscW-1:0]    osc_freq;
  } item_t;

  typedef struct packed {
    logic [CodeW-1:0] code_a;
    logic [CodeW-1:0] code_b;
    logic             invalid;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       div_start;
    logic [1:0] sel;
    logic       take_mp;
    logic       take_divs;
    logic       take_val;
    logic       norm_step;
    logic       store_a;
    logic       store_b;
    logic       emit;
    logic       emit_bad;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_bad;
    logic div_zero;
    logic div_done;
    logic fits;
  } status_t;

endpackage

@@ rtl/rtbe_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module rtbe_div
  import rtbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DataW-1:0] dividend,
  input  logic [DataW-1:0] divisor,
  output logic             done,
  output logic [DataW-1:0] quotient
);

  logic [DataW:0]   rem;
  logic [DataW-1:0] quo;
  logic [DataW-1:0] dsr;
  logic [CntW-1:0]  cnt;
  logic             running;
  logic [DataW:0]   shifted;
  logic             fits_dsr;

  // Bring down the next dividend bit and trial-subtract
  always_comb begin
    shifted  = {rem[DataW-1:0], quo[DataW-1]};
    fits_dsr = shifted >= {1'b0, dsr};
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CntW'(DataW);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Data: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (running) begin
      rem <= fits_dsr ? (shifted - {1'b0, dsr}) : shifted;
      quo <= {quo[DataW-2:0], fits_dsr};
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/rtbe_datapath.sv @@
`timescale 1ns / 1ps

module rtbe_datapath
  import rtbe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  cmd_t    cmd,
  output status_t status,
  output result_t result
);

  item_t            item_q;
  logic [DataW-1:0] budget;
  logic [DataW-1:0] mp;
  logic [DataW-1:0] div_a;
  logic [DataW-1:0] div_b;
  logic [DataW-1:0] val;
  logic [ExpW-1:0]  expo;
  logic [CodeW-1:0] code_a;
  logic [CodeW-1:0] code_b;

  logic [DataW-1:0] dividend;
  logic [DataW-1:0] divisor;
  logic             div_done;
  logic [DataW-1:0] quotient;
  logic [43:0]      mp_prod;
  logic [DataW-1:0] scaled_a;
  logic [DataW-1:0] scaled_b;
  logic [CodeW-1:0] code_now;

  // Select divider operands
  always_comb begin
    case (cmd.sel)
      SEL_OSC: begin
        dividend = OSC_NUMERATOR;
        divisor  = {{(DataW-OscW){1'b0}}, item_q.osc_freq};
      end
      SEL_A: begin
        dividend = budget + (div_a >> 1);
        divisor  = div_a;
      end
      SEL_B: begin
        dividend = budget + (div_b >> 1);
        divisor  = div_b;
      end
      default: begin
        dividend = OSC_NUMERATOR;
        divisor  = {{(DataW-OscW){1'b0}}, item_q.osc_freq};
      end
    endcase
  end

  rtbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Macro period product at 44 bits; scaled divisors kept to 32 bits
  always_comb begin
    mp_prod  = {12'b0, quotient} * {{(44-12){1'b0}}, MACRO_MULT};
    scaled_a = mp * SCALE_A;
    scaled_b = mp * SCALE_B;
    code_now = {8'(expo), val[7:0]};
  end

  // Hold the working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
      budget <= (DataW'(item.budget_ms) * MS_TO_US - BUDGET_OFFSET_US) << 12;
    end
    if (cmd.take_mp) begin
      mp <= mp_prod[DataW+5:6];
    end
    if (cmd.take_divs) begin
      div_a <= scaled_a >> 6;
      div_b <= scaled_b >> 6;
    end
    // Drop one from the quotient, then normalize one bit per cycle
    if (cmd.take_val) begin
      val  <= quotient - 1'b1;
      expo <= '0;
    end else if (cmd.norm_step) begin
      val  <= val >> 1;
      expo <= expo + 1'b1;
    end
    if (cmd.store_a) begin
      code_a <= code_now;
    end
    if (cmd.store_b) begin
      code_b <= code_now;
    end
    if (cmd.emit) begin
      result.invalid <= cmd.emit_bad;
      result.code_a  <= cmd.emit_bad ? '0 : code_a;
      result.code_b  <= cmd.emit_bad ? '0 : code_b;
    end
  end

  // Report status to the controller
  always_comb begin
    status.in_bad   = (item_q.osc_freq == '0) ||
                      (item_q.budget_ms < BUDGET_MIN_MS) ||
                      (item_q.budget_ms > BUDGET_MAX_MS);
    status.div_zero = (div_a == '0) || (div_b == '0);
    status.div_done = div_done;
    status.fits     = (val & HIGH_MASK) == '0;
  end

endmodule

@@ rtl/rtbe_ctrl.sv @@
`timescale 1ns / 1ps

module rtbe_ctrl
  import rtbe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_DIV0  = 4'd2;
  localparam logic [3:0] S_SCALE = 4'd3;
  localparam logic [3:0] S_ZCHK  = 4'd4;
  localparam logic [3:0] S_DIVA  = 4'd5;
  localparam logic [3:0] S_NORMA = 4'd6;
  localparam logic [3:0] S_DIVB  = 4'd7;
  localparam logic [3:0] S_NORMB = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       bad;
  logic       bad_next;

  // Sequence the divisions and normalizations
  always_comb begin
    state_next = state;
    bad_next   = bad;
    cmd        = '0;
    cmd.sel    = SEL_OSC;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          bad_next   = 1'b0;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.in_bad) begin
          bad_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.sel       = SEL_OSC;
          state_next    = S_DIV0;
        end
      end
      S_DIV0: begin
        if (status.div_done) begin
          cmd.take_mp = 1'b1;
          state_next  = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.take_divs = 1'b1;
        state_next    = S_ZCHK;
      end
      S_ZCHK: begin
        if (status.div_zero) begin
          bad_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.sel       = SEL_A;
          state_next    = S_DIVA;
        end
      end
      S_DIVA: begin
        cmd.sel = SEL_A;
        if (status.div_done) begin
          cmd.take_val = 1'b1;
          state_next   = S_NORMA;
        end
      end
      S_NORMA: begin
        if (status.fits) begin
          cmd.store_a   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.sel       = SEL_B;
          state_next    = S_DIVB;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_DIVB: begin
        cmd.sel = SEL_B;
        if (status.div_done) begin
          cmd.take_val = 1'b1;
          state_next   = S_NORMB;
        end
      end
      S_NORMB: begin
        if (status.fits) begin
          cmd.store_b = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_DONE: begin
        cmd.emit     = 1'b1;
        cmd.emit_bad = bad;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bad   <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      bad   <= bad_next;
      done  <= cmd.emit;
    end
  end

  assign busy = state != S_IDLE;

endmodule

@@ rtl/range_timing_budget_encoder.sv @@
`timescale 1ns / 1ps

// Timing budget encoder for a time-of-flight range sensor.
// Command channel: drive item (budget_ms, osc_freq) and raise start; the beat
// is taken at a rising edge with start high and busy low. busy stays high
// until the result is presented.
// Result channel: done is high for exactly one cycle with result (code_a,
// code_b, invalid) valid in that cycle. The receiver cannot stall; the
// result register holds its value until the next beat overwrites it.
// A rejected item (zero frequency or budget outside 10..200) goes from the
// check straight to the result; a zero divisor is caught after the first division.
// A valid item makes three 32-step passes through the single restoring
// divider (frequency reciprocal, then one per code), each followed on the
// code paths by up to 24 one-bit normalize shifts.
// One item is in flight at a time; busy drops in the cycle that carries the
// result, so the next beat can be taken at the edge that takes the result.
// Reset (rst, synchronous) returns the controller to idle and clears done;
// nothing is pending afterwards.
module range_timing_budget_encoder
  import rtbe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result
);

  cmd_t    cmd;
  status_t status;

  rtbe_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  rtbe_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule

@@ rtl/rtbe_checker.sv @@
`timescale 1ns / 1ps

module rtbe_props
  import rtbe_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input item_t   item,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // A result beat only appears once the block has dropped back to idle
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  // An accepted command beat makes the block busy
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("command beat accepted but block not busy");

  // Each result strobe lasts a single cycle
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // Rejected parameters give zero codes
  assert property (@(posedge clk) disable iff (rst)
    (done && result.invalid) |-> (result.code_a == '0 && result.code_b == '0))
    else $error("invalid result with nonzero codes");

  // Reset leaves the block idle with nothing pending
  assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("block not idle after reset");

endmodule

bind range_timing_budget_encoder rtbe_props u_chk (.*);

@@ tb/rtbe_checker.sv @@
`timescale 1ns / 1ps

module rtbe_checker
  import rtbe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  item_t   item,
  input  logic    done,
  input  result_t result,
  output int      fails,
  output int      pending,
  output int      checked,
  output int      rejected
);

  typedef struct packed {
    item_t   cmd;
    result_t codes;
  } expect_entry_t;

  // Expected timeout codes, oldest command first
  expect_entry_t timeout_codes_q[$];

  // Divide with rounding, drop one, then shift down until the value fits 8 bits
  function automatic logic [CodeW-1:0] timeout_code(logic [DataW-1:0] span_us,
                                                    logic [DataW-1:0] divisor);
    logic [DataW-1:0] value;
    logic [7:0]       exponent;
    value    = (span_us + (divisor >> 1)) / divisor - 32'd1;
    exponent = '0;
    while ((value & HIGH_MASK) != '0) begin
      value    = value >> 1;
      exponent = exponent + 8'd1;
    end
    return {exponent, value[7:0]};
  endfunction

  function automatic result_t predict_codes(item_t cmd);
    result_t          r;
    logic [63:0]      wide;
    logic [DataW-1:0] span_us;
    logic [DataW-1:0] period;
    logic [DataW-1:0] div_a;
    logic [DataW-1:0] div_b;
    r         = '0;
    r.invalid = 1'b1;
    if (cmd.osc_freq == '0 || cmd.budget_ms < BUDGET_MIN_MS ||
        cmd.budget_ms > BUDGET_MAX_MS) begin
      return r;
    end
    // Budget in microseconds less the fixed offset, scaled by 2^12
    span_us = (DataW'(cmd.budget_ms) * MS_TO_US - BUDGET_OFFSET_US) << 12;
    // Macro period keeps 32 bits of the product, from bit 6 up
    wide   = 64'(MACRO_MULT) * (64'(OSC_NUMERATOR) / 64'(cmd.osc_freq));
    period = wide[37:6];
    div_a  = (period * SCALE_A) >> 6;
    div_b  = (period * SCALE_B) >> 6;
    if (div_a == '0 || div_b == '0) begin
      return r;
    end
    r.code_a  = timeout_code(span_us, div_a);
    r.code_b  = timeout_code(span_us, div_b);
    r.invalid = 1'b0;
    return r;
  endfunction

  // Retire results before recording a new command beat at the same edge
  always @(posedge clk) begin
    expect_entry_t head;
    if (!rst) begin
      if (done) begin
        if (timeout_codes_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result: expected none, got code_a %h code_b %h invalid %b",
                   $time, result.code_a, result.code_b, result.invalid);
        end else begin
          head = timeout_codes_q.pop_front();
          checked++;
          if (head.codes.invalid) rejected++;
          if (result.code_a !== head.codes.code_a) begin
            fails++;
            $display("%0t: code_a mismatch (budget %0d osc %h): expected %h, got %h",
                     $time, head.cmd.budget_ms, head.cmd.osc_freq,
                     head.codes.code_a, result.code_a);
          end
          if (result.code_b !== head.codes.code_b) begin
            fails++;
            $display("%0t: code_b mismatch (budget %0d osc %h): expected %h, got %h",
                     $time, head.cmd.budget_ms, head.cmd.osc_freq,
                     head.codes.code_b, result.code_b);
          end
          if (result.invalid !== head.codes.invalid) begin
            fails++;
            $display("%0t: invalid mismatch (budget %0d osc %h): expected %b, got %b",
                     $time, head.cmd.budget_ms, head.cmd.osc_freq,
                     head.codes.invalid, result.invalid);
          end
        end
      end
      if (start && !busy) begin
        timeout_codes_q.push_back({item, predict_codes(item)});
      end
    end
    pending = timeout_codes_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rtbe_pkg::*;

  localparam int RandomItems  = 430;
  localparam int SteadyTail   = 60;
  // Shortest scaled budget: 10 ms less the offset, times 2^12
  localparam logic [DataW-1:0] MinSpanUs = 32'd30720000;

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    done;
  result_t result;

  int fails;
  int pending;
  int checked;
  int rejected;
  int sent;
  int directed_cnt;

  // Frequency words that hit a zero divisor or a zero rounded quotient
  logic [OscW-1:0] zero_div_osc[$];
  logic [OscW-1:0] zero_quot_osc[$];

  always #5 clk = ~clk;

  range_timing_budget_encoder i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  rtbe_checker i_checker (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .fails    (fails),
    .pending  (pending),
    .checked  (checked),
    .rejected (rejected)
  );

  // Scaled divisor for a frequency word, used only to pick corner stimulus
  function automatic logic [DataW-1:0] scaled_divisor(logic [OscW-1:0] osc,
                                                      logic [DataW-1:0] scale);
    logic [63:0]      wide;
    logic [DataW-1:0] period;
    wide   = 64'(MACRO_MULT) * (64'(OSC_NUMERATOR) / 64'(osc));
    period = wide[37:6];
    return (period * scale) >> 6;
  endfunction

  function automatic logic [OscW-1:0] pick_osc(ref logic [OscW-1:0] pool[$]);
    if (pool.size() == 0) return OscW'($urandom_range(1, 65535));
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  // Mostly well-formed commands, with corner frequencies and rejects mixed in
  function automatic item_t random_item();
    item_t it;
    int    roll;
    roll = $urandom_range(0, 99);
    it.budget_ms = BudgetW'($urandom_range(BUDGET_MIN_MS, BUDGET_MAX_MS));
    if (roll < 60) begin
      it.osc_freq = OscW'($urandom_range(1, 65535));
    end else if (roll < 70) begin
      it.osc_freq = OscW'($urandom_range(1, 1024));
    end else if (roll < 78) begin
      it.osc_freq  = pick_osc(zero_quot_osc);
      it.budget_ms = BudgetW'($urandom_range(BUDGET_MIN_MS, 20));
    end else if (roll < 83) begin
      it.osc_freq = pick_osc(zero_div_osc);
    end else if (roll < 88) begin
      it.osc_freq  = '0;
      it.budget_ms = BudgetW'($urandom_range(0, 1023));
    end else begin
      it.budget_ms = BudgetW'($urandom_range(0, 1023));
      it.osc_freq  = OscW'($urandom_range(0, 65535));
    end
    return it;
  endfunction

  // Hold the command until a rising edge takes it with busy low
  task automatic send_item(item_t it);
    @(negedge clk);
    start = 1'b1;
    item  = it;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  initial begin
    item_t directed[$];
    logic [DataW-1:0] da;
    logic [DataW-1:0] db;
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    sent  = 0;

    // Find frequency words behind the divisor corner cases
    for (int f = 1; f < 65536; f++) begin
      da = scaled_divisor(OscW'(f), SCALE_A);
      db = scaled_divisor(OscW'(f), SCALE_B);
      if (da == '0 || db == '0) begin
        zero_div_osc.push_back(OscW'(f));
      end else if ((da - (da >> 1)) > MinSpanUs || (db - (db >> 1)) > MinSpanUs) begin
        zero_quot_osc.push_back(OscW'(f));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Field extremes, range edges, zero frequency and the divisor corners
    directed.push_back({10'd0,    16'h8000});
    directed.push_back({10'd1023, 16'hFFFF});
    directed.push_back({10'd9,    16'd100});
    directed.push_back({10'd10,   16'h0000});
    directed.push_back({10'd10,   16'hFFFF});
    directed.push_back({10'd200,  16'hFFFF});
    directed.push_back({10'd201,  16'hFFFF});
    directed.push_back({10'd200,  16'd3});
    directed.push_back({10'd10,   16'd3});
    directed.push_back({10'd512,  16'h5555});
    directed.push_back({10'd100,  16'hAAAA});
    directed.push_back({10'd57,   16'h1234});
    directed.push_back({10'd199,  16'h7FFF});
    directed.push_back({10'd200,  16'd1});
    directed.push_back({10'd10,   16'd1});
    for (int k = 0; k < 3 && k < zero_div_osc.size(); k++) begin
      directed.push_back({BudgetW'(10 + 90 * k), zero_div_osc[k]});
    end
    for (int k = 0; k < 4 && k < zero_quot_osc.size(); k++) begin
      directed.push_back({BUDGET_MIN_MS, zero_quot_osc[k * (zero_quot_osc.size() / 4)]});
    end
    directed_cnt = directed.size();
    foreach (directed[k]) send_item(directed[k]);

    for (int n = 0; n < RandomItems; n++) begin
      // Drain the pipe once mid-run before sending more
      if (n == RandomItems / 2) begin
        @(negedge clk);
        start = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      if (n < RandomItems - SteadyTail && $urandom_range(0, 3) == 0) begin
        idle_cycles($urandom_range(1, 16));
      end
      send_item(random_item());
    end

    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Sent %0d commands (%0d directed); %0d results checked, %0d of them rejected",
             sent, directed_cnt, checked, rejected);
    $display("Corner frequency words available: %0d zero-divisor, %0d zero-quotient",
             zero_div_osc.size(), zero_quot_osc.size());
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: a correct run ends well inside this bound
  initial begin
    #5_000_000;
    $display("Run timed out with %0d results still expected", pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
